// ===== rtl/mtile_pkg.sv =====
// ----------------------------------------------------------------------------
// mtile_pkg: shared types and constants for the 4x4 matmul tile
// Tile geometry, field widths and the control bundle that the top level
// sends down to every tile cell.
// ----------------------------------------------------------------------------
package mtile_pkg;

  localparam int unsigned TILE_DIM        = 4;
  localparam int unsigned TILE_CELLS      = TILE_DIM * TILE_DIM;
  localparam int unsigned IDX_WIDTH       = $clog2(TILE_CELLS);
  localparam int unsigned CNT_WIDTH       = $clog2(TILE_CELLS + 1);
  localparam int unsigned POS_WIDTH       = $clog2(TILE_DIM);
  localparam int unsigned SUM_WIDTH       = 48;
  localparam int unsigned OUT_FIELD_BITS  = 2 * POS_WIDTH + SUM_WIDTH;
  localparam int unsigned OUT_TDATA_WIDTH = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam int unsigned OPERAND_WIDTH_DEF = 16;
  localparam int unsigned ACC_WIDTH_DEF     = 48;

  // Per-cycle controls shared by all cells
  typedef struct packed {
    logic load_prod;  // capture a new operand pair product
    logic acc_en;     // add the held product into the accumulator
    logic snap;       // move the final sum into the drain chain, clear acc
    logic shift;      // advance the drain chain by one cell
  } cell_ctl_t;

endpackage

// ===== rtl/mtile_cell.sv =====
// ----------------------------------------------------------------------------
// mtile_cell: one multiply-accumulate cell of the tile
// Registers one product, adds it into its accumulator, and holds one slot
// of the drain chain that shifts finished sums toward the output.
// ----------------------------------------------------------------------------
module mtile_cell #(
  parameter int unsigned OPERAND_WIDTH = mtile_pkg::OPERAND_WIDTH_DEF,
  parameter int unsigned ACC_WIDTH     = mtile_pkg::ACC_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mtile_pkg::cell_ctl_t      ctl_i,
  input  logic [OPERAND_WIDTH-1:0]  a_i,
  input  logic [OPERAND_WIDTH-1:0]  b_i,
  input  logic [ACC_WIDTH-1:0]      drain_next_i,
  output logic [ACC_WIDTH-1:0]      drain_o
);
  import mtile_pkg::*;

  localparam int unsigned PROD_WIDTH = 2 * OPERAND_WIDTH;

  logic signed [PROD_WIDTH-1:0] prod_d, prod_q;
  logic [ACC_WIDTH-1:0]         prod_ext;
  logic [ACC_WIDTH-1:0]         acc_d, acc_q;
  logic [ACC_WIDTH-1:0]         sum;
  logic [ACC_WIDTH-1:0]         drain_d, drain_q;

  assign prod_d = $signed(a_i) * $signed(b_i);

  generate
    if (ACC_WIDTH >= PROD_WIDTH) begin : g_ext
      assign prod_ext = {{(ACC_WIDTH - PROD_WIDTH){prod_q[PROD_WIDTH-1]}}, prod_q};
    end else begin : g_trunc
      assign prod_ext = prod_q[ACC_WIDTH-1:0];
    end
  endgenerate

  assign sum = acc_q + prod_ext;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.snap) begin
      acc_d = '0;
    end else if (ctl_i.acc_en) begin
      acc_d = sum;
    end
  end

  always_comb begin
    drain_d = drain_q;
    if (ctl_i.snap) begin
      drain_d = sum;
    end else if (ctl_i.shift) begin
      drain_d = drain_next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_prod) begin
      prod_q <= prod_d;
    end
    drain_q <= drain_d;
  end

  assign drain_o = drain_q;

endmodule

// ===== rtl/matmul_tile_4x4_accumulate.sv =====
// ----------------------------------------------------------------------------
// matmul_tile_4x4_accumulate: output-stationary 4x4 matrix-multiply tile
// Sixteen MAC cells accumulate outer products; finished sums drain out in
// row-major order through a shift chain.
// ----------------------------------------------------------------------------
// The tile takes one step of the shared dimension per cycle while
// s_axis_tready is high: a transfer carries a column of A and a row of B,
// and all sixteen cells multiply and accumulate in parallel (product
// register, then accumulator), so inputs stream back to back at one
// transfer per cycle unless a closing step stalls. The transfer marked
// tlast closes the tile: its sums move into a 16-slot drain chain and the
// accumulators restart from zero, so the next tile's steps keep flowing
// while the results shift out one transfer per cycle while m_axis_tready
// is high, row-major, with tlast on the sixteenth. The output tvalid rises
// once the closing step has left the product register and its sums are in
// the drain chain. The drain chain is the limit: a closing step waits in
// the product stage, with s_axis_tready low, until the previous tile's
// sixteen results have all been taken, so short tiles are paced by the output.
// ----------------------------------------------------------------------------
module matmul_tile_4x4_accumulate #(
  parameter int unsigned OPERAND_WIDTH = mtile_pkg::OPERAND_WIDTH_DEF,
  parameter int unsigned ACC_WIDTH     = mtile_pkg::ACC_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // a_row0, a_row1, a_row2, a_row3, b_col0, b_col1, b_col2, b_col3
  input  logic [8*OPERAND_WIDTH-1:0]             s_axis_tdata,
  input  logic                                   s_axis_tlast,  // step_last
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tile_row, tile_col, sum_value, zero fill
  output logic [mtile_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata,
  output logic                                   m_axis_tlast,  // tile_done
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready
);
  import mtile_pkg::*;

  logic                  in_fire;
  logic                  out_fire;
  logic                  stall;
  logic                  p_vld_d, p_vld_q;
  logic                  p_last_d, p_last_q;
  logic [CNT_WIDTH-1:0]  cnt_d, cnt_q;
  logic [CNT_WIDTH-1:0]  idx_full;
  logic [IDX_WIDTH-1:0]  idx;
  logic [SUM_WIDTH-1:0]  sum_out;
  cell_ctl_t             ctl;

  logic [ACC_WIDTH-1:0]  drain [TILE_CELLS+1];

  // Hold a closing step until the drain chain is empty
  assign stall         = p_vld_q && p_last_q && (cnt_q != '0);
  assign s_axis_tready = !stall;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  assign ctl.load_prod = in_fire;
  assign ctl.acc_en    = p_vld_q && !stall;
  assign ctl.snap      = p_vld_q && p_last_q && !stall;
  assign ctl.shift     = out_fire;

  always_comb begin
    p_vld_d  = p_vld_q;
    p_last_d = p_last_q;
    if (!stall) begin
      p_vld_d  = in_fire;
      p_last_d = s_axis_tlast;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctl.snap) begin
      cnt_d = CNT_WIDTH'(TILE_CELLS);
    end else if (out_fire) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q  <= 1'b0;
      p_last_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      p_vld_q  <= p_vld_d;
      p_last_q <= p_last_d;
      cnt_q    <= cnt_d;
    end
  end

  assign drain[TILE_CELLS] = '0;

  for (genvar r = 0; r < TILE_DIM; r++) begin : g_row
    for (genvar c = 0; c < TILE_DIM; c++) begin : g_col
      mtile_cell #(
        .OPERAND_WIDTH (OPERAND_WIDTH),
        .ACC_WIDTH     (ACC_WIDTH)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctl_i        (ctl),
        .a_i          (s_axis_tdata[r*OPERAND_WIDTH +: OPERAND_WIDTH]),
        .b_i          (s_axis_tdata[(TILE_DIM+c)*OPERAND_WIDTH +: OPERAND_WIDTH]),
        .drain_next_i (drain[r*TILE_DIM+c+1]),
        .drain_o      (drain[r*TILE_DIM+c])
      );
    end
  end

  generate
    if (ACC_WIDTH >= SUM_WIDTH) begin : g_sum_trunc
      assign sum_out = drain[0][SUM_WIDTH-1:0];
    end else begin : g_sum_pad
      assign sum_out = {{(SUM_WIDTH - ACC_WIDTH){1'b0}}, drain[0]};
    end
  endgenerate

  // Position of the sum at the head of the chain
  assign idx_full = CNT_WIDTH'(TILE_CELLS) - cnt_q;
  assign idx      = idx_full[IDX_WIDTH-1:0];

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tlast  = (cnt_q == CNT_WIDTH'(1));
  assign m_axis_tdata  = {{(OUT_TDATA_WIDTH - OUT_FIELD_BITS){1'b0}},
                          sum_out,
                          idx[POS_WIDTH-1:0],
                          idx[IDX_WIDTH-1:POS_WIDTH]};

`ifndef SYNTHESIS
  a_snap_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.snap |-> cnt_q == '0)
    else $error("tile sums loaded while the drain chain was busy");

  a_snap_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.snap |=> (cnt_q == CNT_WIDTH'(TILE_CELLS)) && m_axis_tvalid)
    else $error("drain chain not full after a tile closed");

  a_last_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && m_axis_tlast) |=> (cnt_q == '0) || (cnt_q == CNT_WIDTH'(TILE_CELLS)))
    else $error("drain count inconsistent after the final sum");
`endif

endmodule
